>>> src/swt_pkg.sv
package swt_pkg;

	localparam int SEQ_W       = 16;
	localparam int VERDICT_W   = 2;
	localparam int ACK_FIELD_W = 32;
	localparam int ACK_IDX_W   = $clog2(ACK_FIELD_W);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_DUP    = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_STALE  = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_UNUSED = 2'd3;

	// head of the front queue as seen by the back end
	typedef struct packed {
		logic             valid;
		logic [SEQ_W-1:0] seq;
	} queue_out_t;

endpackage

>>> src/swt_front.sv
module swt_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [swt_pkg::SEQ_W-1:0] packet_sequence,
	output logic                      busy,
	input  logic                      pop,
	output swt_pkg::queue_out_t       head
);
	import swt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [SEQ_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push;
	logic             do_pop;

	assign busy   = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (fill_q != '0);

	assign head.valid = (fill_q != '0);
	assign head.seq   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= packet_sequence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> src/swt_back.sv
module swt_back #(
	parameter int HISTORY_DEPTH = 64,
	parameter int ACK_BITS      = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swt_pkg::queue_out_t            head,
	output logic                           pop,
	output logic                           strobe,
	output logic [swt_pkg::VERDICT_W-1:0]  verdict,
	output logic [swt_pkg::SEQ_W-1:0]      ack_sequence,
	output logic [swt_pkg::ACK_FIELD_W-1:0] ack_field
);
	import swt_pkg::*;

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int ACK_W = (ACK_BITS < ACK_FIELD_W) ? ACK_BITS : ACK_FIELD_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DECIDE
	} state_t;

	state_t            state_q;
	logic [SEQ_W-1:0]  mem [HISTORY_DEPTH];
	logic [SEQ_W-1:0]  rd_data_s1;
	logic              rd_valid_s1;
	logic              rd_first_s1;

	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [SEQ_W-1:0]  latest_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [CNT_W-1:0]  walk_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic              dup_q;
	logic [ACK_FIELD_W-1:0] ack_old_q;
	logic [ACK_FIELD_W-1:0] ack_new_q;

	logic              full;
	logic              issue;
	logic              accept;
	logic [SEQ_W-1:0]  dist_latest;
	logic [SEQ_W-1:0]  dist_old;
	logic [SEQ_W-1:0]  dist_new;
	logic              hit_old;
	logic              hit_new;

	assign full   = (count_q == CNT_W'(HISTORY_DEPTH));
	assign issue  = (state_q == S_WALK) && (walk_q != count_q);
	assign pop    = (state_q == S_IDLE) && head.valid;

	// bit 15 of seq - latest set means older, or exactly half a range away
	assign dist_latest = seq_q - latest_q;
	assign accept      = !dup_q && !dist_latest[SEQ_W-1];

	// ack bit positions seen from the current latest and from the candidate
	assign dist_old = latest_q - rd_data_s1 - 1'b1;
	assign dist_new = seq_q - rd_data_s1 - 1'b1;
	assign hit_old  = dist_old < SEQ_W'(ACK_W);
	// the oldest entry drops out when a push lands on a full history
	assign hit_new  = (dist_new < SEQ_W'(ACK_W)) && !(rd_first_s1 && full);

	always_ff @(posedge clk) begin
		if ((state_q == S_DECIDE) && accept) begin
			mem[tail_q] <= seq_q;
		end
		rd_data_s1 <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			latest_q     <= '0;
			seq_q        <= '0;
			walk_q       <= '0;
			rd_ptr_q     <= '0;
			rd_valid_s1  <= 1'b0;
			rd_first_s1  <= 1'b0;
			dup_q        <= 1'b0;
			ack_old_q    <= '0;
			ack_new_q    <= '0;
			strobe       <= 1'b0;
			verdict      <= VERDICT_ACCEPT;
			ack_sequence <= '0;
			ack_field    <= '0;
		end else begin
			strobe      <= 1'b0;
			rd_valid_s1 <= issue;
			rd_first_s1 <= issue && (walk_q == '0);

			if (rd_valid_s1) begin
				if (rd_data_s1 == seq_q) begin
					dup_q <= 1'b1;
				end
				if (hit_old) begin
					ack_old_q <= ack_old_q | (ACK_FIELD_W'(1) << dist_old[ACK_IDX_W-1:0]);
				end
				if (hit_new) begin
					ack_new_q <= ack_new_q | (ACK_FIELD_W'(1) << dist_new[ACK_IDX_W-1:0]);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						seq_q     <= head.seq;
						walk_q    <= '0;
						rd_ptr_q  <= head_q;
						dup_q     <= 1'b0;
						ack_old_q <= '0;
						ack_new_q <= '0;
						state_q   <= S_WALK;
					end
				end
				S_WALK: begin
					if (issue) begin
						walk_q   <= walk_q + 1'b1;
						rd_ptr_q <= (rd_ptr_q == IDX_W'(HISTORY_DEPTH - 1)) ?
							'0 : rd_ptr_q + 1'b1;
					end else if (!rd_valid_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					strobe <= 1'b1;
					if (dup_q) begin
						verdict <= VERDICT_DUP;
					end else if (!accept) begin
						verdict <= VERDICT_STALE;
					end else begin
						verdict <= VERDICT_ACCEPT;
					end
					if (accept) begin
						ack_sequence <= seq_q;
						ack_field    <= ack_new_q;
						latest_q     <= seq_q;
						tail_q       <= (tail_q == IDX_W'(HISTORY_DEPTH - 1)) ?
							'0 : tail_q + 1'b1;
						if (full) begin
							head_q <= (head_q == IDX_W'(HISTORY_DEPTH - 1)) ?
								'0 : head_q + 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						ack_sequence <= latest_q;
						ack_field    <= ack_old_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/reliable_seq_window_tracker.sv
// Receive-side sequence filter. A beat is taken when start is high and busy is low; up to
// two beats queue ahead of the tracker. For each packet the tracker walks all valid history
// entries (at most HISTORY_DEPTH): it reads the history memory one entry a cycle through
// its single read port, checking for a duplicate and building the ack field for both the
// old and the candidate latest number in the same pass. Every packet yields one result,
// shown for one cycle with strobe high; the receiver must take it then, as nothing holds
// it back.
module reliable_seq_window_tracker #(
	parameter int HISTORY_DEPTH = 64,
	parameter int ACK_BITS      = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [swt_pkg::SEQ_W-1:0]       packet_sequence,
	output logic                            strobe,
	output logic [swt_pkg::VERDICT_W-1:0]   verdict,
	output logic [swt_pkg::SEQ_W-1:0]       ack_sequence,
	output logic [swt_pkg::ACK_FIELD_W-1:0] ack_field
);
	import swt_pkg::*;

	queue_out_t q_head;
	logic       q_pop;

	swt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.packet_sequence (packet_sequence),
		.busy            (busy),
		.pop             (q_pop),
		.head            (q_head)
	);

	swt_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.ACK_BITS      (ACK_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.pop          (q_pop),
		.strobe       (strobe),
		.verdict      (verdict),
		.ack_sequence (ack_sequence),
		.ack_field    (ack_field)
	);

endmodule

>>> src/swt_checker.sv
module swt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            strobe,
	input logic [swt_pkg::VERDICT_W-1:0]   verdict,
	input logic [swt_pkg::ACK_FIELD_W-1:0] ack_field
);
	import swt_pkg::*;

	// each result needs a full pass, so strobes never come back to back
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("two result beats in consecutive cycles");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (verdict != VERDICT_UNUSED))
		else $error("unused verdict code");

	// the queue only fills on an accepted beat
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an input beat");

	// result fields settle only with a strobe
	a_field_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!strobe && !$past(strobe) |-> $stable(ack_field))
		else $error("ack field moved without a result beat");

endmodule

bind reliable_seq_window_tracker swt_checker u_swt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.verdict   (verdict),
	.ack_field (ack_field)
);
